FILE: rtl/core/tol_pkg.sv
// ----------------------------------------------------------------------------
// tol_pkg
// shared types and constants of the transaction output list parser
// ----------------------------------------------------------------------------
package tol_pkg;

  // longest list in bytes, default of the top level parameter
  localparam int unsigned MaxBytesDefault = 65535;

  // depth of the queue between the front and the parser
  localparam int unsigned QueueDepth = 4;

  // compact-size markers
  localparam logic [7:0] MarkerU16 = 8'hfd;
  localparam logic [7:0] MarkerU32 = 8'hfe;

  // widths of the extended compact-size fields in bytes
  localparam logic [3:0] ExtLenU16 = 4'd2;
  localparam logic [3:0] ExtLenU32 = 4'd4;
  localparam logic [3:0] ExtLenU64 = 4'd8;

  // width of an amount in bytes
  localparam logic [3:0] AmountLen = 4'd8;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_MISMATCH  = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_TRUNCATED = 3'd3,
    ST_TRAILING  = 3'd4,
    ST_TOO_LONG  = 3'd5
  } status_e;

  typedef enum logic [6:0] {
    PH_COUNT_MARK  = 7'b0000001,
    PH_COUNT_EXT   = 7'b0000010,
    PH_AMOUNT      = 7'b0000100,
    PH_SCRIPT_MARK = 7'b0001000,
    PH_SCRIPT_EXT  = 7'b0010000,
    PH_SCRIPT_SKIP = 7'b0100000,
    PH_DONE        = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } tol_in_t;

  typedef struct packed {
    logic        list_ok;
    logic [2:0]  status;
    logic [63:0] total_value;
    logic [15:0] suffix_length;
  } tol_out_t;

  // one classified byte as it travels through the queue
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       is_ext;
    logic [3:0] ext_len;
  } tol_item_t;

endpackage

FILE: rtl/core/tx_output_list_parser.sv
// ----------------------------------------------------------------------------
// tx_output_list_parser
// streaming checker for a serialized transaction output list
// ----------------------------------------------------------------------------
// usage:
//   in channel  : one list byte per beat with a last-byte flag
//                 (in_valid_i / in_ready_o / in_data_i)
//   out channel : one result beat per list, sent for the last byte
//                 (out_valid_o / out_ready_i / out_data_o)
//   config      : cfg_we_i writes cfg_wdata_i into the expected output count;
//                 the user must write it only while no list is in flight (not enforced)
//   throughput  : one byte per cycle while no result waits: the parser takes
//                 one queued byte each cycle (one 64-bit add and compare per byte)
//   result      : the accepted last byte is stored in a queue entry, then
//                 parsed from the queue straight into the output register
//   stall       : while the result waits, the parser holds and the queue
//                 keeps taking bytes until its four entries are full
//   reset       : queue empty, no result pending, parser back to reading the
//                 count marker, expected output count cleared to zero
// ----------------------------------------------------------------------------
module tx_output_list_parser
  import tol_pkg::*;
#(
  parameter int unsigned MaxBytes = MaxBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  tol_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output tol_out_t    out_data_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  // expected output count, compared when the count field completes
  logic [31:0] expected_q;

  // front to parser queue signals
  logic        item_valid;
  logic        item_pop;
  tol_item_t   item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q <= '0;
    end else if (cfg_we_i) begin
      expected_q <= cfg_wdata_i;
    end
  end

  // front: takes bytes, tags compact-size markers, buffers them
  tol_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop),
    .item_o       (item)
  );

  // back: parses the list and holds the result until taken
  tol_parser #(
    .MaxBytes (MaxBytes)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .want_count_i (expected_q),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .item_i       (item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

FILE: rtl/core/tol_front.sv
// ----------------------------------------------------------------------------
// tol_front
// accepts bytes, tags compact-size markers and queues them for the parser
// ----------------------------------------------------------------------------
module tol_front
  import tol_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  tol_in_t   in_data_i,
  output logic      item_valid_o,
  input  logic      item_pop_i,
  output tol_item_t item_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  tol_item_t           mem_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  tol_item_t           item_new;
  logic                push;
  logic                pop;

  // classify the byte as a compact-size marker
  always_comb begin
    item_new.data_byte = in_data_i.data_byte;
    item_new.last_byte = in_data_i.last_byte;
    item_new.is_ext    = (in_data_i.data_byte >= MarkerU16);
    if (in_data_i.data_byte == MarkerU16) begin
      item_new.ext_len = ExtLenU16;
    end else if (in_data_i.data_byte == MarkerU32) begin
      item_new.ext_len = ExtLenU32;
    end else begin
      item_new.ext_len = ExtLenU64;
    end
  end

  assign in_ready_o   = (count_q != CntW'(QueueDepth));
  assign item_valid_o = (count_q != '0);
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_pop_i && item_valid_o;

  always_comb begin
    wr_ptr_d = push ? PtrW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop ? PtrW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = CntW'(count_q + 1'b1);
    end else if (pop && !push) begin
      count_d = CntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_new;
    end
  end

  assign item_o = mem_q[rd_ptr_q];

endmodule

FILE: rtl/core/tol_parser.sv
// ----------------------------------------------------------------------------
// tol_parser
// walks the output list one queued byte a cycle while no result waits and builds the result
// ----------------------------------------------------------------------------
module tol_parser
  import tol_pkg::*;
#(
  parameter int unsigned MaxBytes = MaxBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] want_count_i,
  input  logic        item_valid_i,
  output logic        item_pop_o,
  input  tol_item_t   item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output tol_out_t    out_data_o
);

  localparam int unsigned SeenW = $clog2(MaxBytes + 2);

  phase_e           phase_q, phase_d;
  logic [3:0]       fbl_q, fbl_d;
  logic [2:0]       shift_q, shift_d;
  logic [63:0]      acc_q, acc_d;
  logic [63:0]      total_q, total_d;
  logic [31:0]      outs_q, outs_d;
  logic [63:0]      script_q, script_d;
  logic [SeenW-1:0] seen_q, seen_d;
  logic [3:0]       prefix_q, prefix_d;
  status_e          err_q, err_d;
  logic             out_valid_q, out_valid_d;
  tol_out_t         out_q, out_d;

  logic             pop;
  logic [7:0]       b;
  logic [63:0]      acc_take;
  logic [3:0]       fbl_take;
  logic             take_done;
  logic [64:0]      sum;
  logic [63:0]      count_val;
  logic [63:0]      script_val;
  logic [31:0]      outs_dec;
  logic [63:0]      script_dec;
  logic [31:0]      suffix32;
  status_e          err_fin;

  assign pop        = item_valid_i && (!out_valid_q || out_ready_i);
  assign item_pop_o = pop;

  always_comb begin
    b          = item_i.data_byte;
    acc_take   = acc_q | (64'(b) << {shift_q, 3'b000});
    fbl_take   = (fbl_q != 4'd0) ? 4'(fbl_q - 4'd1) : 4'd0;
    take_done  = (fbl_take == 4'd0);
    sum        = {1'b0, total_q} + {1'b0, acc_take};
    count_val  = (phase_q == PH_COUNT_MARK) ? 64'(b) : acc_take;
    script_val = (phase_q == PH_SCRIPT_MARK) ? 64'(b) : acc_take;
    outs_dec   = (outs_q != 32'd0) ? 32'(outs_q - 32'd1) : 32'd0;
    script_dec = (script_q != 64'd0) ? 64'(script_q - 64'd1) : 64'd0;

    phase_d     = phase_q;
    fbl_d       = fbl_q;
    shift_d     = shift_q;
    acc_d       = acc_q;
    total_d     = total_q;
    outs_d      = outs_q;
    script_d    = script_q;
    seen_d      = seen_q;
    prefix_d    = prefix_q;
    err_d       = err_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    err_fin     = err_q;
    suffix32    = '0;

    if (pop) begin
      if (seen_q <= SeenW'(MaxBytes)) begin
        seen_d = SeenW'(seen_q + 1'b1);
      end
      if (err_q == ST_OK) begin
        if (seen_d > SeenW'(MaxBytes)) begin
          err_d = ST_TOO_LONG;
        end else begin
          case (phase_q)
            PH_COUNT_MARK, PH_COUNT_EXT: begin
              if (phase_q == PH_COUNT_MARK) begin
                prefix_d = 4'd1;
              end else begin
                prefix_d = 4'(prefix_q + 4'd1);
                fbl_d    = fbl_take;
                shift_d  = 3'(shift_q + 3'd1);
                acc_d    = acc_take;
              end
              if (phase_q == PH_COUNT_MARK && item_i.is_ext) begin
                fbl_d   = item_i.ext_len;
                shift_d = '0;
                acc_d   = '0;
                phase_d = PH_COUNT_EXT;
              end else if (phase_q == PH_COUNT_MARK || take_done) begin
                // count complete: check against the register
                if (count_val != 64'(want_count_i)) begin
                  err_d = ST_MISMATCH;
                end else if (count_val == 64'd0) begin
                  phase_d = PH_DONE;
                end else begin
                  outs_d  = count_val[31:0];
                  fbl_d   = AmountLen;
                  shift_d = '0;
                  acc_d   = '0;
                  phase_d = PH_AMOUNT;
                end
              end
            end
            PH_AMOUNT: begin
              fbl_d   = fbl_take;
              shift_d = 3'(shift_q + 3'd1);
              acc_d   = acc_take;
              if (take_done) begin
                if (sum[64]) begin
                  err_d = ST_OVERFLOW;
                end else begin
                  total_d = sum[63:0];
                  phase_d = PH_SCRIPT_MARK;
                end
              end
            end
            PH_SCRIPT_MARK, PH_SCRIPT_EXT, PH_SCRIPT_SKIP: begin
              if (phase_q == PH_SCRIPT_EXT) begin
                fbl_d   = fbl_take;
                shift_d = 3'(shift_q + 3'd1);
                acc_d   = acc_take;
              end
              if (phase_q == PH_SCRIPT_MARK && item_i.is_ext) begin
                fbl_d   = item_i.ext_len;
                shift_d = '0;
                acc_d   = '0;
                phase_d = PH_SCRIPT_EXT;
              end else if (phase_q == PH_SCRIPT_SKIP) begin
                script_d = script_dec;
                if (script_dec == 64'd0) begin
                  outs_d = outs_dec;
                  if (outs_dec == 32'd0) begin
                    phase_d = PH_DONE;
                  end else begin
                    fbl_d   = AmountLen;
                    shift_d = '0;
                    acc_d   = '0;
                    phase_d = PH_AMOUNT;
                  end
                end
              end else if (phase_q == PH_SCRIPT_MARK || take_done) begin
                if (script_val != 64'd0) begin
                  script_d = script_val;
                  phase_d  = PH_SCRIPT_SKIP;
                end else begin
                  outs_d = outs_dec;
                  if (outs_dec == 32'd0) begin
                    phase_d = PH_DONE;
                  end else begin
                    fbl_d   = AmountLen;
                    shift_d = '0;
                    acc_d   = '0;
                    phase_d = PH_AMOUNT;
                  end
                end
              end
            end
            default: begin
              err_d = ST_TRAILING;
            end
          endcase
        end
      end

      if (item_i.last_byte) begin
        err_fin = err_d;
        if (err_d == ST_OK && phase_d != PH_DONE) begin
          err_fin = ST_TRUNCATED;
        end
        if (32'(seen_d) >= 32'(prefix_d)) begin
          suffix32 = 32'(seen_d) - 32'(prefix_d);
        end
        out_valid_d = 1'b1;
        if (err_fin == ST_OK) begin
          out_d.list_ok       = 1'b1;
          out_d.status        = ST_OK;
          out_d.total_value   = total_d;
          out_d.suffix_length = (suffix32 > 32'hffff) ? 16'hffff : suffix32[15:0];
        end else begin
          out_d.list_ok       = 1'b0;
          out_d.status        = err_fin;
          out_d.total_value   = '0;
          out_d.suffix_length = '0;
        end
        // restart for the next list
        phase_d  = PH_COUNT_MARK;
        fbl_d    = '0;
        shift_d  = '0;
        acc_d    = '0;
        total_d  = '0;
        outs_d   = '0;
        script_d = '0;
        seen_d   = '0;
        prefix_d = '0;
        err_d    = ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_COUNT_MARK;
      fbl_q       <= '0;
      shift_q     <= '0;
      acc_q       <= '0;
      total_q     <= '0;
      outs_q      <= '0;
      script_q    <= '0;
      seen_q      <= '0;
      prefix_q    <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      fbl_q       <= fbl_d;
      shift_q     <= shift_d;
      acc_q       <= acc_d;
      total_q     <= total_d;
      outs_q      <= outs_d;
      script_q    <= script_d;
      seen_q      <= seen_d;
      prefix_q    <= prefix_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/core/tol_checker.sv
// ----------------------------------------------------------------------------
// tol_checker
// port level checks of the output list parser
// ----------------------------------------------------------------------------
module tol_checker
  import tol_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input tol_out_t out_data_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // ok flag agrees with status
  a_ok_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.list_ok == (out_data_o.status == ST_OK)))
    else $error("list_ok disagrees with status");

  // failed lists report no total and no suffix
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.list_ok |->
      out_data_o.total_value == 64'd0 && out_data_o.suffix_length == 16'd0)
    else $error("failed list carries a total or a suffix length");

endmodule

bind tx_output_list_parser tol_checker u_tol_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the transaction output list parser: lists are sent
// byte by byte, every accepted byte runs through a local parser model and
// each result beat is compared with the oldest predicted list result
// ----------------------------------------------------------------------------
module tb_top;
  import tol_pkg::*;

  // bench constants
  localparam int unsigned MaxBytes    = MaxBytesDefault;
  localparam int unsigned StallLimit  = 2000;  // cycles with no beat on any port
  localparam int unsigned HoldCycles  = 300;   // long receiver hold-off
  localparam int unsigned DrainCycles = 4;     // idle wait after the last result is taken
  localparam int unsigned MaxReports  = 10;
  localparam logic [7:0]  MarkerU64   = 8'hff;
  localparam logic [7:0]  MaxDirect   = 8'hfc;  // largest count held in one byte
  localparam logic [63:0] AllOnes     = 64'hffff_ffff_ffff_ffff;

  // compact-size encodings the list builder can choose
  typedef enum int {FormByte, FormU16, FormU32, FormU64, FormAny} cs_form_e;

  // dut ports
  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  tol_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  tol_out_t    out_data;
  logic        cfg_we    = 1'b0;
  logic [31:0] cfg_wdata = '0;

  // bench control
  bit          idle_en   = 1'b1;
  int unsigned hold_left = 0;
  int unsigned stall_cycles = 0;
  int unsigned mismatches = 0;

  // local parser model: configuration and per-list state
  logic [31:0] want_outputs;
  phase_e      ph;
  logic [3:0]  field_left;
  logic [2:0]  field_shift;
  logic [63:0] field_acc;
  logic [63:0] amount_sum;
  logic [31:0] outputs_left;
  logic [63:0] script_left;
  logic [16:0] byte_count;
  logic [3:0]  prefix_len;
  status_e     first_error;

  // predicted list results, oldest first
  tol_out_t    expected_list_results[$];
  tol_out_t    want_result;

  // bytes of the list being built
  logic [7:0]  list_bytes[$];

  tx_output_list_parser i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // parser model
  // --------------------------------------------------------------------------

  function automatic void clear_parse();
    ph           = PH_COUNT_MARK;
    field_left   = '0;
    field_shift  = '0;
    field_acc    = '0;
    amount_sum   = '0;
    outputs_left = '0;
    script_left  = '0;
    byte_count   = '0;
    prefix_len   = '0;
    first_error  = ST_OK;
  endfunction

  function automatic void open_field(logic [3:0] nbytes, phase_e next_ph);
    field_left  = nbytes;
    field_shift = '0;
    field_acc   = '0;
    ph          = next_ph;
  endfunction

  // width of the little-endian field that follows a marker
  function automatic logic [3:0] compact_len(logic [7:0] marker);
    if (marker == MarkerU16) return ExtLenU16;
    if (marker == MarkerU32) return ExtLenU32;
    return ExtLenU64;
  endfunction

  // shifts one byte into the open field, true once the field is complete
  function automatic bit absorb_byte(logic [7:0] b);
    field_acc   = field_acc | (64'(b) << {field_shift, 3'b000});
    field_shift = field_shift + 3'd1;
    if (field_left != 0) field_left = field_left - 4'd1;
    return field_left == 0;
  endfunction

  function automatic void count_done(logic [63:0] n);
    if (n != {32'd0, want_outputs}) begin
      first_error = ST_MISMATCH;
    end else if (n == 0) begin
      ph = PH_DONE;
    end else begin
      outputs_left = n[31:0];
      open_field(AmountLen, PH_AMOUNT);
    end
  endfunction

  function automatic void output_done();
    if (outputs_left != 0) outputs_left = outputs_left - 32'd1;
    if (outputs_left == 0) begin
      ph = PH_DONE;
    end else begin
      open_field(AmountLen, PH_AMOUNT);
    end
  endfunction

  function automatic void script_len_done(logic [63:0] n);
    if (n == 0) begin
      output_done();
    end else begin
      script_left = n;
      ph = PH_SCRIPT_SKIP;
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    case (ph)
      PH_COUNT_MARK: begin
        prefix_len = 4'd1;
        if (b < MarkerU16) count_done(64'(b));
        else open_field(compact_len(b), PH_COUNT_EXT);
      end
      PH_COUNT_EXT: begin
        prefix_len = prefix_len + 4'd1;
        if (absorb_byte(b)) count_done(field_acc);
      end
      PH_AMOUNT: begin
        if (absorb_byte(b)) begin
          // overflow when the amount exceeds the room left in 64 bits
          if (field_acc > ~amount_sum) begin
            first_error = ST_OVERFLOW;
          end else begin
            amount_sum = amount_sum + field_acc;
            ph = PH_SCRIPT_MARK;
          end
        end
      end
      PH_SCRIPT_MARK: begin
        if (b < MarkerU16) script_len_done(64'(b));
        else open_field(compact_len(b), PH_SCRIPT_EXT);
      end
      PH_SCRIPT_EXT: begin
        if (absorb_byte(b)) script_len_done(field_acc);
      end
      PH_SCRIPT_SKIP: begin
        if (script_left != 0) script_left = script_left - 64'd1;
        if (script_left == 0) output_done();
      end
      default: begin
        // anything after the final output
        first_error = ST_TRAILING;
      end
    endcase
  endfunction

  // one accepted byte; a result only comes with the last byte of a list
  task automatic parse_list_byte(input logic [7:0] b, input logic last,
                                 output bit has_result, output tol_out_t result);
    logic [16:0] suffix;
    has_result = last;
    result     = '0;
    // byte counter saturates one above the size limit
    if (byte_count <= 17'(MaxBytes)) byte_count = byte_count + 17'd1;
    if (first_error == ST_OK) begin
      if (byte_count > 17'(MaxBytes)) first_error = ST_TOO_LONG;
      else parse_byte(b);
    end
    if (last) begin
      if (first_error == ST_OK && ph != PH_DONE) first_error = ST_TRUNCATED;
      if (first_error == ST_OK) begin
        suffix = (byte_count >= 17'(prefix_len)) ? byte_count - 17'(prefix_len) : '0;
        result.list_ok       = 1'b1;
        result.status        = ST_OK;
        result.total_value   = amount_sum;
        result.suffix_length = (suffix > 17'h0ffff) ? 16'hffff : suffix[15:0];
      end else begin
        result.status = first_error;
      end
      clear_parse();
    end
  endtask

  // --------------------------------------------------------------------------
  // list builder
  // --------------------------------------------------------------------------

  function automatic void put_le(logic [63:0] v, int unsigned nbytes);
    for (int unsigned i = 0; i < nbytes; i++) list_bytes.push_back(v[8*i +: 8]);
  endfunction

  // compact size, a too narrow form is widened to fit the value
  function automatic void put_compact(logic [63:0] v, cs_form_e form);
    cs_form_e f;
    f = form;
    if (f == FormAny) begin
      f = ($urandom_range(99) < 60) ? FormByte : cs_form_e'($urandom_range(1, 3));
    end
    if (f == FormByte && v > 64'(MaxDirect)) f = FormU16;
    if (f == FormU16 && v > 64'hffff) f = FormU32;
    if (f == FormU32 && v > 64'hffff_ffff) f = FormU64;
    case (f)
      FormByte: list_bytes.push_back(v[7:0]);
      FormU16: begin
        list_bytes.push_back(MarkerU16);
        put_le(v, 2);
      end
      FormU32: begin
        list_bytes.push_back(MarkerU32);
        put_le(v, 4);
      end
      default: begin
        list_bytes.push_back(MarkerU64);
        put_le(v, 8);
      end
    endcase
  endfunction

  // amount, script length and a script body of random bytes
  function automatic void put_output(logic [63:0] amount, logic [63:0] script_len,
                                     cs_form_e form);
    put_le(amount, 8);
    put_compact(script_len, form);
    for (longint unsigned i = 0; i < script_len; i++) list_bytes.push_back(8'($urandom));
  endfunction

  // mostly small amounts so that sums rarely overflow, some full width
  function automatic logic [63:0] random_amount();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 6) return {24'd0, 8'($urandom), 32'($urandom)};
    if (pick < 9) return {32'($urandom), 32'($urandom)};
    return ~64'($urandom_range(255));
  endfunction

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // one input beat; the model runs at the edge that accepts it
  task automatic send_byte(input logic [7:0] b, input logic last);
    bit       has_result;
    tol_out_t result;
    while (idle_en && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, last_byte: last};
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    parse_list_byte(b, last, has_result, result);
    if (has_result) expected_list_results.push_back(result);
  endtask

  task automatic send_list();
    for (int i = 0; i < list_bytes.size(); i++) begin
      send_byte(list_bytes[i], i == list_bytes.size() - 1);
    end
    list_bytes.delete();
  endtask

  // block is idle once every result is in and its pipeline has emptied
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_list_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_count_cfg(input logic [31:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we       <= 1'b0;
    want_outputs  = value;
  endtask

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= !(idle_en && $urandom_range(99) < 8);
    end
  end

  // --------------------------------------------------------------------------
  // result checker
  // --------------------------------------------------------------------------

  function automatic void report_mismatch(string what, tol_out_t want, tol_out_t got);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("mismatch, %s: expected ok=%0b status=%0d total=%h suffix=%0d",
               what, want.list_ok, want.status, want.total_value, want.suffix_length);
      $display("           got ok=%0b status=%0d total=%h suffix=%0d",
               got.list_ok, got.status, got.total_value, got.suffix_length);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (expected_list_results.size() == 0) begin
        report_mismatch("result beat with nothing expected", '0, out_data);
      end else begin
        want_result = expected_list_results.pop_front();
        if (out_data.list_ok !== want_result.list_ok ||
            out_data.status !== want_result.status ||
            out_data.total_value !== want_result.total_value ||
            out_data.suffix_length !== want_result.suffix_length) begin
          report_mismatch("result fields", want_result, out_data);
        end
      end
    end
  end

  // watchdog on cycles without any beat or register write
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == StallLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // field extremes, every status but too long and each special case once
  task automatic test_directed_cases();
    write_count_cfg(32'd0);
    // zero outputs, the list ends right after the count
    list_bytes.push_back(8'h00);
    send_list();
    // a byte after a zero count is trailing
    list_bytes.push_back(8'h00);
    list_bytes.push_back(8'h55);
    send_list();
    // non-canonical zero count in three bytes
    put_compact(64'd0, FormU16);
    send_list();
    // mismatch latches, the bytes after it are only counted
    list_bytes.push_back(8'h01);
    put_le(AllOnes, 8);
    list_bytes.push_back(8'h00);
    send_list();

    write_count_cfg(32'd1);
    // largest amount with an empty script
    list_bytes.push_back(8'h01);
    put_output(AllOnes, 64'd0, FormByte);
    send_list();
    // largest one-byte count, mismatch
    list_bytes.push_back(MaxDirect);
    send_list();
    // cut inside the amount
    list_bytes.push_back(8'h01);
    put_le(64'h00a5_5a00, 3);
    send_list();
    // cut on the count marker
    list_bytes.push_back(MarkerU16);
    send_list();
    // cut inside the script body
    list_bytes.push_back(8'h01);
    put_le(64'd1, 8);
    put_compact(64'd512, FormU16);
    put_le(AllOnes, 2);
    send_list();
    // one byte past the last output
    list_bytes.push_back(8'h01);
    put_output(64'h0123_4567_89ab_cdef, 64'd5, FormByte);
    list_bytes.push_back(8'h00);
    send_list();
    // huge script length, ends truncated
    list_bytes.push_back(8'h01);
    put_le(64'd7, 8);
    put_compact(AllOnes, FormU64);
    list_bytes.push_back(8'h00);
    send_list();
    // 8-byte count wrong only in its upper bytes
    put_compact(64'h0100_0000_0000_0001, FormU64);
    send_list();
    // non-canonical count and script length
    put_compact(64'd1, FormU32);
    put_output(64'h8000_0000_0000_0000, 64'd0, FormU32);
    send_list();
    // smallest script length that needs the 2-byte form
    list_bytes.push_back(8'h01);
    put_output(64'd0, 64'h00fd, FormU16);
    send_list();

    write_count_cfg(32'd2);
    // sum overflows on the second amount
    list_bytes.push_back(8'h02);
    put_output(AllOnes, 64'd0, FormByte);
    put_output(64'd1, 64'd0, FormByte);
    send_list();
    // sum lands exactly on the top value
    list_bytes.push_back(8'h02);
    put_output(64'h8000_0000_0000_0000, 64'd0, FormByte);
    put_output(64'h7fff_ffff_ffff_ffff, 64'd1, FormByte);
    send_list();
    // cut inside a 4-byte script length
    put_compact(64'd2, FormU64);
    put_le(64'd3, 8);
    list_bytes.push_back(MarkerU32);
    list_bytes.push_back(8'h00);
    send_list();

    write_count_cfg(32'hffff_ffff);
    // largest count matches but the list is far too short
    put_compact(64'hffff_ffff, FormU32);
    put_output(64'd9, 64'd0, FormByte);
    send_list();
  endtask

  // receiver holds off while short lists keep coming, input must stall
  task automatic test_result_backpressure();
    write_count_cfg(32'd0);
    hold_left <= HoldCycles;
    repeat (24) begin
      list_bytes.push_back(8'h00);
      send_list();
    end
  endtask

  // phases of random lists under changing expected counts
  task automatic send_random_lists(input int unsigned byte_budget);
    int unsigned sent;
    int unsigned kind;
    int unsigned n_out;
    int unsigned cut;
    logic [31:0] cfg;
    sent = 0;
    while (sent < byte_budget) begin
      case ($urandom_range(9))
        0:       cfg = 32'd0;
        1:       cfg = 32'hffff_ffff;
        2:       cfg = $urandom;
        default: cfg = $urandom_range(1, 3);
      endcase
      write_count_cfg(cfg);
      repeat ($urandom_range(3, 8)) begin
        kind = $urandom_range(99);
        if (kind < 12) begin
          // noise
          repeat ($urandom_range(1, 16)) list_bytes.push_back(8'($urandom));
        end else begin
          // wrong count in some lists, the configured count in the rest
          if (kind < 20) put_compact(64'(cfg) + 64'($urandom_range(1, 2)), FormAny);
          else put_compact(64'(cfg), FormAny);
          n_out = (cfg > 4) ? $urandom_range(0, 2) : cfg;
          repeat (n_out) begin
            put_output(random_amount(),
                       ($urandom_range(9) == 0) ? 64'($urandom_range(250, 300))
                                                : 64'($urandom_range(0, 12)),
                       FormAny);
          end
          if (kind >= 20 && kind < 30) begin
            // trailing bytes
            repeat ($urandom_range(1, 3)) list_bytes.push_back(8'($urandom));
          end else if (kind >= 30 && kind < 42 && list_bytes.size() > 1) begin
            // cut short at a random point
            cut = $urandom_range(1, list_bytes.size() - 1);
            while (list_bytes.size() > cut) void'(list_bytes.pop_back());
          end
        end
        sent += list_bytes.size();
        send_list();
      end
    end
  endtask

  task automatic test_random_lists();
    send_random_lists(280);
  endtask

  // back to back beats on both sides
  task automatic test_no_idle_stretch();
    drain_results();
    idle_en <= 1'b0;
    send_random_lists(150);
    drain_results();
    idle_en <= 1'b1;
  endtask

  initial begin
    want_outputs = '0;
    clear_parse();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_result_backpressure();
    test_no_idle_stretch();
    test_random_lists();

    drain_results();
    if (mismatches == 0 && expected_list_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
